// ----- rtl/cigar_pileup_base_counter_defines.svh -----
// Assertion macros for the RTL of the pileup base counter.
`ifndef CIGAR_PILEUP_BASE_COUNTER_DEFINES_SVH
`define CIGAR_PILEUP_BASE_COUNTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define CPBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define CPBC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CPBC_ASSERT_IMP(label, ante, cons, msg)
`define CPBC_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/cpbc_pkg.sv -----
`default_nettype none
package cpbc_pkg;

  localparam int COUNT_W           = 32;
  localparam int COUNT_COLS        = 6;
  localparam int DEFAULT_REF_DEPTH = 4096;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_OP    = 2'd1;
  localparam logic [1:0] ACT_BASE  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  localparam logic [3:0] OP_MATCH  = 4'd0;
  localparam logic [3:0] OP_INSERT = 4'd1;
  localparam logic [3:0] OP_DELETE = 4'd2;
  localparam logic [3:0] OP_SKIP   = 4'd3;
  localparam logic [3:0] OP_EQUAL  = 4'd7;
  localparam logic [3:0] OP_DIFF   = 4'd8;

  localparam logic [2:0] COL_A   = 3'd0;
  localparam logic [2:0] COL_C   = 3'd1;
  localparam logic [2:0] COL_G   = 3'd2;
  localparam logic [2:0] COL_T   = 3'd3;
  localparam logic [2:0] COL_DEL = 3'd4;
  localparam logic [2:0] COL_N   = 3'd5;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_N = 8'h4E;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_MATCH,
    KIND_INSERT
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BASE_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] position;
    logic [3:0]  op_code;
    logic [12:0] op_length;
    logic [7:0]  base_char;
    logic [7:0]  base_quality;
    logic [2:0]  counter_select;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_value;
    logic               range_error;
  } out_item_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] col;
  } col_sel_t;

  function automatic col_sel_t base_column(logic [7:0] ch);
    col_sel_t sel;
    sel.hit = 1'b1;
    sel.col = COL_A;
    case (ch)
      CHAR_A:  sel.col = COL_A;
      CHAR_C:  sel.col = COL_C;
      CHAR_G:  sel.col = COL_G;
      CHAR_T:  sel.col = COL_T;
      CHAR_N:  sel.col = COL_N;
      default: sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cpbc_stream_if.sv -----
`default_nettype none
interface cpbc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/cpbc_ram.sv -----
`default_nettype none
module cpbc_ram #(
  parameter int WIDTH = cpbc_pkg::COUNT_W,
  parameter int DEPTH = cpbc_pkg::DEFAULT_REF_DEPTH * cpbc_pkg::COUNT_COLS
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cigar_pileup_base_counter.sv -----
// Channel  | Dir | Payload                | Handshake
// items    | in  | cpbc_pkg::in_item_t    | valid/ready
// results  | out | cpbc_pkg::out_item_t   | valid/ready, registered
// cfg      | in  | min_quality, 8 bits    | valid/ready, always ready
//
// After reset a clearing pass writes zero to all REF_DEPTH*6 counters, one per cycle;
// items wait for it to finish, cfg writes are taken throughout.
// Start, operation and uncounted bases are taken in ST_IDLE alone. A counted base reads
// its counter and writes it back in ST_BASE_WR. A base beyond the reference and a query
// go through ST_RESULT, which waits while the result register is full. A deletion or
// skip reads each deletion counter and writes it back (ST_DEL_RD, ST_DEL_WR), as the
// count memory read is registered; positions past the end raise an error word via ST_RESULT.
`default_nettype none
`include "cigar_pileup_base_counter_defines.svh"
module cigar_pileup_base_counter #(
  parameter int REF_DEPTH = cpbc_pkg::DEFAULT_REF_DEPTH
) (
  input wire logic      clk,
  input wire logic      rst,
  cpbc_stream_if.sink   items,
  cpbc_stream_if.source results,
  cpbc_stream_if.sink   cfg
);

  localparam int MEM_DEPTH = REF_DEPTH * cpbc_pkg::COUNT_COLS;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int CUR_W     = $clog2(REF_DEPTH + 1);
  localparam int PW        = (CUR_W > 12) ? CUR_W : 12;

  function automatic logic [AW-1:0] cell_addr(logic [PW-1:0] pos, logic [2:0] col);
    logic [AW-1:0] p;
    p = AW'(pos);
    return (p << 2) + (p << 1) + AW'(col);
  endfunction

  cpbc_pkg::state_t    state, state_next;
  cpbc_pkg::kind_t     kind, kind_next;
  logic [CUR_W-1:0]    cursor, cursor_next;
  logic [12:0]         remaining, remaining_next;
  logic [7:0]          min_quality;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic                del_err, del_err_next;
  logic                out_valid, out_valid_next;
  cpbc_pkg::out_item_t out_q, out_next;
  logic [2:0]          upd_col, upd_col_next;
  logic                res_err, res_err_next;
  logic                res_zero, res_zero_next;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [cpbc_pkg::COUNT_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [cpbc_pkg::COUNT_W-1:0]  ram_rdata;
  logic [cpbc_pkg::COUNT_W-1:0]  sat_inc;

  cpbc_pkg::in_item_t  item;
  cpbc_pkg::col_sel_t  col_sel;
  logic                accept;
  logic [PW-1:0]       pos_ext;
  logic [PW-1:0]       cur_ext;
  logic                pos_in_ref;
  logic                cur_in_ref;
  logic                is_match_op;
  logic                is_del_op;
  logic                base_live;
  logic                qual_ok;
  logic                res_stalled;
  logic                wb_phase;
  logic                err_word;

  cpbc_ram #(
    .WIDTH(cpbc_pkg::COUNT_W),
    .DEPTH(MEM_DEPTH)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign item          = items.data;
  assign items.ready   = (state == cpbc_pkg::ST_IDLE);
  assign accept        = items.valid && items.ready;
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;
  assign results.data  = out_q;

  assign pos_ext     = PW'(item.position);
  assign cur_ext     = PW'(cursor);
  assign pos_in_ref  = pos_ext < PW'(REF_DEPTH);
  assign cur_in_ref  = cur_ext < PW'(REF_DEPTH);
  assign is_match_op = (item.op_code == cpbc_pkg::OP_MATCH) ||
                       (item.op_code == cpbc_pkg::OP_EQUAL) ||
                       (item.op_code == cpbc_pkg::OP_DIFF);
  assign is_del_op   = (item.op_code == cpbc_pkg::OP_DELETE) ||
                       (item.op_code == cpbc_pkg::OP_SKIP);
  assign base_live   = (remaining != 13'd0) && (kind != cpbc_pkg::KIND_NONE);
  assign qual_ok     = item.base_quality >= min_quality;
  assign col_sel     = cpbc_pkg::base_column(item.base_char);
  // counters stop at all ones
  assign sat_inc     = (ram_rdata == '1) ? ram_rdata : ram_rdata + cpbc_pkg::COUNT_W'(1);

  assign res_stalled = (state == cpbc_pkg::ST_RESULT) && out_valid && !results.ready;
  assign wb_phase    = (state == cpbc_pkg::ST_BASE_WR) || (state == cpbc_pkg::ST_DEL_WR);
  assign err_word    = out_valid && out_q.range_error;

  always_comb begin
    state_next     = state;
    kind_next      = kind;
    cursor_next    = cursor;
    remaining_next = remaining;
    clr_addr_next  = clr_addr;
    del_err_next   = del_err;
    upd_col_next   = upd_col;
    res_err_next   = res_err;
    res_zero_next  = res_zero;
    out_next       = out_q;
    out_valid_next = out_valid && !results.ready;
    ram_we         = 1'b0;
    ram_waddr      = cell_addr(cur_ext, upd_col);
    ram_wdata      = sat_inc;
    ram_re         = 1'b0;
    ram_raddr      = cell_addr(cur_ext, cpbc_pkg::COL_DEL);

    case (state)
      cpbc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
        if (clr_addr == AW'(MEM_DEPTH - 1)) begin
          state_next = cpbc_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      cpbc_pkg::ST_IDLE: begin
        if (accept) begin
          case (item.action)
            cpbc_pkg::ACT_START: begin
              cursor_next    = pos_in_ref ? CUR_W'(item.position) : CUR_W'(REF_DEPTH);
              kind_next      = cpbc_pkg::KIND_NONE;
              remaining_next = 13'd0;
            end
            cpbc_pkg::ACT_OP: begin
              kind_next      = cpbc_pkg::KIND_NONE;
              remaining_next = 13'd0;
              if (is_match_op) begin
                kind_next      = cpbc_pkg::KIND_MATCH;
                remaining_next = item.op_length;
              end else if (item.op_code == cpbc_pkg::OP_INSERT) begin
                kind_next      = cpbc_pkg::KIND_INSERT;
                remaining_next = item.op_length;
              end else if (is_del_op) begin
                // walk the deletion with remaining as the position count
                remaining_next = item.op_length;
                del_err_next   = 1'b0;
                state_next     = cpbc_pkg::ST_DEL_RD;
              end
            end
            cpbc_pkg::ACT_BASE: begin
              if (base_live) begin
                remaining_next = remaining - 13'd1;
                if (kind == cpbc_pkg::KIND_MATCH) begin
                  if (!cur_in_ref) begin
                    res_err_next  = 1'b1;
                    res_zero_next = 1'b1;
                    state_next    = cpbc_pkg::ST_RESULT;
                  end else if (qual_ok && col_sel.hit) begin
                    ram_re       = 1'b1;
                    ram_raddr    = cell_addr(cur_ext, col_sel.col);
                    upd_col_next = col_sel.col;
                    state_next   = cpbc_pkg::ST_BASE_WR;
                  end else begin
                    cursor_next = cursor + CUR_W'(1);
                  end
                end
              end
            end
            cpbc_pkg::ACT_QUERY: begin
              ram_re        = 1'b1;
              ram_raddr     = cell_addr(pos_ext, item.counter_select);
              res_err_next  = !pos_in_ref;
              res_zero_next = !pos_in_ref ||
                              (item.counter_select >= 3'(cpbc_pkg::COUNT_COLS));
              state_next    = cpbc_pkg::ST_RESULT;
            end
            default: begin
              state_next = cpbc_pkg::ST_IDLE;
            end
          endcase
        end
      end

      cpbc_pkg::ST_BASE_WR: begin
        ram_we      = 1'b1;
        cursor_next = cursor + CUR_W'(1);
        state_next  = cpbc_pkg::ST_IDLE;
      end

      cpbc_pkg::ST_DEL_RD: begin
        if (remaining == 13'd0) begin
          if (del_err) begin
            res_err_next  = 1'b1;
            res_zero_next = 1'b1;
            state_next    = cpbc_pkg::ST_RESULT;
          end else begin
            state_next = cpbc_pkg::ST_IDLE;
          end
        end else if (cur_in_ref) begin
          ram_re       = 1'b1;
          upd_col_next = cpbc_pkg::COL_DEL;
          state_next   = cpbc_pkg::ST_DEL_WR;
        end else begin
          // cursor is parked at the end: the rest of the walk only flags
          del_err_next   = 1'b1;
          remaining_next = 13'd0;
        end
      end

      cpbc_pkg::ST_DEL_WR: begin
        ram_we         = 1'b1;
        cursor_next    = cursor + CUR_W'(1);
        remaining_next = remaining - 13'd1;
        state_next     = cpbc_pkg::ST_DEL_RD;
      end

      cpbc_pkg::ST_RESULT: begin
        // hold until the result register is free
        if (!out_valid || results.ready) begin
          out_next.count_value = res_zero ? '0 : ram_rdata;
          out_next.range_error = res_err;
          out_valid_next       = 1'b1;
          state_next           = cpbc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cpbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cpbc_pkg::ST_CLEAR;
      kind        <= cpbc_pkg::KIND_NONE;
      cursor      <= '0;
      remaining   <= '0;
      min_quality <= '0;
      clr_addr    <= '0;
      del_err     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      kind      <= kind_next;
      cursor    <= cursor_next;
      remaining <= remaining_next;
      clr_addr  <= clr_addr_next;
      del_err   <= del_err_next;
      out_valid <= out_valid_next;
      if (cfg.valid && cfg.ready) begin
        min_quality <= cfg.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_q    <= out_next;
    upd_col  <= upd_col_next;
    res_err  <= res_err_next;
    res_zero <= res_zero_next;
  end

  `CPBC_ASSERT_IMP(a_cursor_bound, 1'b1, PW'(cursor) <= PW'(REF_DEPTH), "cursor past reference")
  `CPBC_ASSERT_IMP(a_clear_blocks, state == cpbc_pkg::ST_CLEAR, !items.ready, "item during clear")
  `CPBC_ASSERT_NXT(a_result_holds, res_stalled, state == cpbc_pkg::ST_RESULT, "result dropped")
  `CPBC_ASSERT_IMP(a_error_zero, err_word, out_q.count_value == '0, "error word not zero")
  `CPBC_ASSERT_IMP(a_write_after_read, wb_phase, $past(ram_re), "write back without read")

endmodule
`default_nettype wire

// ----- dv/pileup_count_checker.sv -----
`timescale 1ns / 1ps
module pileup_count_checker
  import cpbc_pkg::*;
#(
  parameter int REF_DEPTH = DEFAULT_REF_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  in_item_t    item_data,
  input  logic        res_valid,
  input  logic        res_ready,
  input  out_item_t   res_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  logic [COUNT_W-1:0] pile [REF_DEPTH*COUNT_COLS];
  int unsigned        cursor;
  int unsigned        bases_left;
  kind_t              op_kind;
  logic [7:0]         qual_floor;
  out_item_t          due_counts [$];
  out_item_t          want;

  task automatic bump(input int unsigned pos, input logic [2:0] col);
    int unsigned k;
    k = pos * COUNT_COLS + col;
    if (pile[k] != {COUNT_W{1'b1}}) pile[k] = pile[k] + 1'b1;
  endtask

  task automatic flag_range();
    out_item_t r;
    r.count_value = '0;
    r.range_error = 1'b1;
    due_counts.push_back(r);
  endtask

  task automatic tally_item(input in_item_t it);
    bit         overflow;
    bit         counted;
    logic [2:0] col;
    out_item_t  reply;
    overflow = 1'b0;
    counted  = 1'b1;
    col      = COL_A;
    case (it.action)
      ACT_START: begin
        cursor     = (it.position < REF_DEPTH) ? it.position : REF_DEPTH;
        op_kind    = KIND_NONE;
        bases_left = 0;
      end
      ACT_OP: begin
        op_kind    = KIND_NONE;
        bases_left = 0;
        case (it.op_code)
          OP_MATCH, OP_EQUAL, OP_DIFF: begin
            op_kind    = KIND_MATCH;
            bases_left = it.op_length;
          end
          OP_INSERT: begin
            op_kind    = KIND_INSERT;
            bases_left = it.op_length;
          end
          OP_DELETE, OP_SKIP: begin
            // walk the whole run; positions past the end only raise the flag
            for (int j = 0; j < it.op_length; j++) begin
              if (cursor < REF_DEPTH) begin
                bump(cursor, COL_DEL);
                cursor++;
              end else begin
                overflow = 1'b1;
              end
            end
            if (overflow) flag_range();
          end
          default: ;
        endcase
      end
      ACT_BASE: begin
        if (bases_left != 0 && op_kind != KIND_NONE) begin
          bases_left--;
          if (op_kind == KIND_MATCH) begin
            if (cursor >= REF_DEPTH) begin
              flag_range();
            end else begin
              if (it.base_quality >= qual_floor) begin
                case (it.base_char)
                  CHAR_A:  col = COL_A;
                  CHAR_C:  col = COL_C;
                  CHAR_G:  col = COL_G;
                  CHAR_T:  col = COL_T;
                  CHAR_N:  col = COL_N;
                  default: counted = 1'b0;
                endcase
                if (counted) bump(cursor, col);
              end
              cursor++;
            end
          end
        end
      end
      ACT_QUERY: begin
        if (it.position >= REF_DEPTH) begin
          flag_range();
        end else begin
          reply.count_value = (it.counter_select <= COL_N) ?
                              pile[it.position * COUNT_COLS + it.counter_select] : '0;
          reply.range_error = 1'b0;
          due_counts.push_back(reply);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (pile[k]) pile[k] = '0;
      cursor      = 0;
      bases_left  = 0;
      op_kind     = KIND_NONE;
      qual_floor  = '0;
      mismatches  = 0;
      due_counts.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (due_counts.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result word, actual count %0d range_error %0b",
                   $time, res_data.count_value, res_data.range_error);
        end else begin
          want = due_counts.pop_front();
          if (res_data.count_value !== want.count_value) begin
            mismatches++;
            $display("%0t: count_value expected %0d actual %0d",
                     $time, want.count_value, res_data.count_value);
          end
          if (res_data.range_error !== want.range_error) begin
            mismatches++;
            $display("%0t: range_error expected %0b actual %0b",
                     $time, want.range_error, res_data.range_error);
          end
        end
      end
      if (cfg_valid && cfg_ready) qual_floor = cfg_data;
      if (item_valid && item_ready) tally_item(item_data);
    end
    outstanding = due_counts.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import cpbc_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int LONG_HOLD  = 400;
  localparam int BASE_SETTLE = 8;

  localparam logic [3:0] OP_SOFT_CLIP = 4'd4;
  localparam logic [3:0] OP_HARD_CLIP = 4'd5;
  localparam logic [3:0] OP_PAD       = 4'd6;
  localparam logic [3:0] OP_BACK      = 4'd9;
  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;
  localparam logic [2:0] SEL_LAST     = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpbc_stream_if #(.payload_t(in_item_t))   item_ch ();
  cpbc_stream_if #(.payload_t(out_item_t))  res_ch ();
  cpbc_stream_if #(.payload_t(logic [7:0])) cfg_ch ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned items_sent   = 0;
  int unsigned settle_need  = BASE_SETTLE;
  int unsigned big_dels_left = 4;
  logic [7:0]  cur_min_q    = '0;
  bit          steady       = 1'b0;
  int          stall_req    = 0;
  int          stall_done   = 0;

  cigar_pileup_base_counter uut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  pileup_count_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_ch.valid),
    .item_ready  (item_ch.ready),
    .item_data   (item_ch.data),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_data    (res_ch.data),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(CLK_PERIOD * 2_000_000);
    $display("Verification failed");
    $finish;
  end

  // result side: random back-pressure or always ready while steady, plus one long hold on request
  initial begin
    int r;
    int n;
    res_ch.ready = 1'b0;
    forever begin
      if (stall_req != stall_done) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        stall_done = stall_req;
      end else if (steady) begin
        @(negedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        n = (r < 65) ? $urandom_range(1, 16) :
            (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        @(negedge clk);
        res_ch.ready <= (r < 65);
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  function automatic int idle_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic in_item_t scrambled_word();
    logic [63:0] raw;
    in_item_t    w;
    raw = {$urandom, $urandom};
    w = raw[$bits(in_item_t)-1:0];
    return w;
  endfunction

  function automatic in_item_t start_word(input logic [11:0] pos);
    in_item_t w;
    w = scrambled_word();
    w.action   = ACT_START;
    w.position = pos;
    return w;
  endfunction

  function automatic in_item_t op_word(input logic [3:0] code, input logic [12:0] len);
    in_item_t w;
    w = scrambled_word();
    w.action    = ACT_OP;
    w.op_code   = code;
    w.op_length = len;
    return w;
  endfunction

  function automatic in_item_t base_word(input logic [7:0] ch, input logic [7:0] q);
    in_item_t w;
    w = scrambled_word();
    w.action       = ACT_BASE;
    w.base_char    = ch;
    w.base_quality = q;
    return w;
  endfunction

  function automatic in_item_t query_word(input logic [11:0] pos, input logic [2:0] sel);
    in_item_t w;
    w = scrambled_word();
    w.action         = ACT_QUERY;
    w.position       = pos;
    w.counter_select = sel;
    return w;
  endfunction

  function automatic logic [11:0] near_end();
    return 12'(DEFAULT_REF_DEPTH - 1 - $urandom_range(0, 15));
  endfunction

  function automatic logic [11:0] pick_start();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 12'($urandom_range(0, 63));
    if (r < 85) return 12'($urandom);
    return near_end();
  endfunction

  function automatic logic [11:0] pick_query(input logic [11:0] origin);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 12'(origin + $urandom_range(0, 9));
    if (r < 75) return 12'($urandom_range(0, 63));
    if (r < 90) return 12'($urandom);
    return near_end();
  endfunction

  function automatic logic [2:0] pick_select();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(COL_N + 1, SEL_LAST));
    return 3'($urandom_range(COL_A, COL_N));
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return CHAR_A;
      1: return CHAR_C;
      2: return CHAR_G;
      3: return CHAR_T;
      4: return CHAR_N;
      5: return CHAR_A;
      6: return CHAR_T;
      7: return CHAR_G;
      default: return 8'($urandom);
    endcase
  endfunction

  // lean towards the threshold so both sides of it are hit
  function automatic logic [7:0] pick_quality();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return cur_min_q;
    if (r == 2) return cur_min_q - 8'd1;
    return 8'($urandom);
  endfunction

  function automatic logic [3:0] pick_match_code();
    case ($urandom_range(0, 2))
      0: return OP_MATCH;
      1: return OP_EQUAL;
      default: return OP_DIFF;
    endcase
  endfunction

  function automatic logic [3:0] pick_ignored_code();
    case ($urandom_range(0, 4))
      0: return OP_SOFT_CLIP;
      1: return OP_HARD_CLIP;
      2: return OP_PAD;
      3: return OP_BACK;
      default: return 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endcase
  endfunction

  function automatic int unsigned pick_run_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 95) return $urandom_range(1, 8);
    return $urandom_range(0, 8191);
  endfunction

  // mostly the exact number of bases, sometimes too few or too many
  function automatic int unsigned base_count(input int unsigned len);
    int r;
    if (len > 10) return $urandom_range(1, 10);
    r = $urandom_range(0, 9);
    if (r == 0 && len > 0) return $urandom_range(0, len - 1);
    if (r == 1) return len + $urandom_range(1, 3);
    return len;
  endfunction

  function automatic logic [12:0] pick_del_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 13'($urandom_range(0, 6));
    if (r < 98 || big_dels_left == 0) return 13'($urandom_range(7, 64));
    big_dels_left--;
    return 13'($urandom_range(0, 8191));
  endfunction

  task automatic push_item(input in_item_t w);
    int          gap;
    int unsigned need;
    @(negedge clk);
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    items_sent++;
    need = BASE_SETTLE;
    if (w.action == ACT_OP && (w.op_code == OP_DELETE || w.op_code == OP_SKIP))
      need = 2 * w.op_length + BASE_SETTLE;
    if (need > settle_need) settle_need = need;
    gap = idle_len();
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // drop valid, wait for every owed result, then let any long deletion finish
  task automatic wait_quiet();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (settle_need) @(negedge clk);
    settle_need = BASE_SETTLE;
  endtask

  task automatic set_min_quality(input logic [7:0] q);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= q;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_min_q = q;
  endtask

  task automatic send_read();
    logic [11:0] origin;
    int unsigned len;
    int unsigned n_bases;
    int          r;
    origin = pick_start();
    push_item(start_word(origin));
    repeat ($urandom_range(1, 5)) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        len = pick_run_len();
        push_item(op_word((r < 45) ? pick_match_code() : OP_INSERT, 13'(len)));
        n_bases = base_count(len);
        repeat (n_bases) push_item(base_word(pick_char(), pick_quality()));
      end else if (r < 85) begin
        push_item(op_word(r[0] ? OP_DELETE : OP_SKIP, pick_del_len()));
      end else begin
        push_item(op_word(pick_ignored_code(), 13'($urandom)));
        repeat ($urandom_range(0, 2)) push_item(base_word(pick_char(), pick_quality()));
      end
    end
    repeat ($urandom_range(1, 3)) push_item(query_word(pick_query(origin), pick_select()));
  endtask

  task automatic run_reads(input int unsigned upto);
    while (items_sent < upto) send_read();
  endtask

  initial begin
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // taken during the clearing pass
    set_min_quality(8'd20);

    push_item(start_word(12'd0));
    push_item(op_word(OP_MATCH, 13'd4));
    push_item(base_word(CHAR_A, 8'd255));
    push_item(base_word(CHAR_C, 8'd20));
    push_item(base_word(CHAR_G, 8'd19));
    push_item(base_word(CHAR_T, 8'd0));
    push_item(base_word(CHAR_N, 8'd255));
    push_item(op_word(OP_EQUAL, 13'd2));
    push_item(base_word(CHAR_N, 8'd20));
    push_item(base_word(8'hFF, 8'd255));
    push_item(op_word(OP_INSERT, 13'd2));
    push_item(base_word(CHAR_A, 8'd255));
    push_item(op_word(OP_SKIP, 13'd3));
    push_item(op_word(OP_DIFF, 13'd1));
    push_item(base_word(CHAR_G, 8'd255));
    push_item(op_word(OP_UNUSED_HI, 13'h1FFF));
    push_item(base_word(CHAR_A, 8'd255));
    push_item(query_word(12'd0, COL_A));
    push_item(query_word(12'd4, COL_N));
    push_item(query_word(12'd7, COL_DEL));
    push_item(query_word(12'd9, SEL_LAST));
    push_item(start_word(12'hFFF));
    push_item(op_word(OP_MATCH, 13'd3));
    push_item(base_word(CHAR_A, 8'd255));
    push_item(base_word(CHAR_C, 8'd0));
    push_item(start_word(12'hFFE));
    push_item(op_word(OP_DELETE, 13'd4));
    push_item(query_word(12'hFFF, COL_A));

    wait_quiet();
    set_min_quality(8'd255);
    run_reads(items_sent + 200);

    wait_quiet();
    set_min_quality(8'd0);
    steady = 1'b1;
    run_reads(items_sent + 200);
    steady = 1'b0;

    // hold the result side while queries keep coming so the input stalls
    wait_quiet();
    set_min_quality(8'($urandom_range(1, 254)));
    stall_req++;
    repeat (40) push_item(query_word(pick_start(), pick_select()));
    run_reads(items_sent + 160);
    wait_quiet();
    run_reads(items_sent + 150);

    wait_quiet();
    set_min_quality(8'd30);
    run_reads(items_sent + 250);

    wait_quiet();
    set_min_quality(8'($urandom));
    run_reads(items_sent + 250);

    wait_quiet();
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
